// ----- hdl/ddo_pkg.sv -----
// Package for the differential-drive odometry block: widths, constants,
// CORDIC arctangent table. No dependencies.
`default_nettype none
package ddo_pkg;
  localparam int CordicSteps = 16;
  localparam int AtanEntries = 24;
  localparam int NumSteps = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;
  localparam logic [22:0] HalfTrackReset = 23'd6554;
  localparam logic [29:0] AngleGain = 30'd341782638;
  localparam logic [29:0] CordicGainQ30 = 30'd652032875;

  // register index, taken from paddr[2]
  localparam logic RegHalfTrack = 1'b0;

  function automatic logic [31:0] atan_turn32(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E; 5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- hdl/ddo_if.sv -----
// Valid/ready channel interfaces for the odometry block.
// Depends on nothing.
`default_nettype none
interface ddo_in_if (input wire logic clk);
  logic valid;
  logic ready;
  logic signed [23:0] left_distance;
  logic signed [23:0] right_distance;
  modport source (output valid, left_distance, right_distance, input ready);
  modport sink (input valid, left_distance, right_distance, output ready);
endinterface

interface ddo_out_if (input wire logic clk);
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0] heading;
  logic signed [23:0] step_x;
  logic signed [23:0] step_y;
  logic signed [15:0] step_heading;
  modport source (output valid, pos_x, pos_y, heading, step_x, step_y, step_heading,
                  input ready);
  modport sink (input valid, pos_x, pos_y, heading, step_x, step_y, step_heading,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/differential_drive_odometry.sv -----
// Top level of the odometry block: APB register, serial divider, CORDIC and
// accumulators. Depends on ddo_pkg and the channel interfaces in ddo_if.sv.
`default_nettype none
// One item at a time: an input beat is taken only while idle, and the next one
// only after the result beat has left. After the input is accepted the block
// runs in order: bit-serial gain multiplication (both products together, one
// multiplier bit per cycle), restoring division for the heading change (one
// quotient bit per cycle), a step to round and saturate the quotient, a step
// to fold the angle and load the CORDIC, 16 CORDIC iterations on one shared
// shift/add unit, and a step to round and accumulate. The result beat is held
// until the receiver takes it, and input ready returns once the block is idle.
module differential_drive_odometry
  import ddo_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  ddo_in_if.sink           in_ch,
  ddo_out_if.source        out_ch
);
  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_QUO, S_LOAD, S_ROT, S_ROUND, S_OUT
  } state_t;

  state_t state;
  logic [22:0] half_track_width;
  logic signed [31:0] x_accum, y_accum;
  logic [15:0] heading_accum;

  logic signed [24:0] diff;      // right - left
  logic signed [24:0] sum;       // floor((left + right) / 2)
  logic [5:0] cnt;
  logic [54:0] mul_acc;          // |diff| * AngleGain, serial shift-add
  logic [54:0] gmul_acc;         // |s| * CordicGainQ30
  logic [29:0] mcand_sh;         // multiplier bits, LSB first
  logic [54:0] rem;
  logic [50:0] quo;
  logic [38:0] den;
  logic signed [15:0] dth;
  logic signed [35:0] cx, cy;
  logic signed [33:0] cz;
  logic [4:0] it;

  // APB: write register 0, read back
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      half_track_width <= HalfTrackReset;
    end else if (psel && penable && pwrite && paddr[2] == RegHalfTrack) begin
      half_track_width <= pwdata[22:0];
    end
  end
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == RegHalfTrack) prdata = {9'd0, half_track_width};
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);

  // serial product step
  logic [24:0] dmag, smag;
  assign dmag = diff[24] ? 25'(-diff) : 25'(diff);
  assign smag = sum[24] ? 25'(-sum) : 25'(sum);

  // quotient rounding (half away from zero) and saturation
  logic round_up;
  logic [51:0] qr;
  logic signed [15:0] dth_sat;
  assign round_up = ({rem[53:0], 1'b0} >= {16'd0, den});
  always_comb begin
    qr = {1'b0, quo} + 52'(round_up);
    if (qr > 52'd32768) qr = 52'd32768;
    if (diff[24]) dth_sat = (qr == 52'd32768) ? -16'sd32768 : -$signed(16'(qr));
    else dth_sat = (qr >= 52'd32767) ? 16'sd32767 : $signed(16'(qr));
  end

  // CORDIC shifts
  logic signed [35:0] xs, ys;
  assign xs = cx >>> it;
  assign ys = cy >>> it;

  // divider trial subtract
  logic [55:0] trial;
  assign trial = {rem[53:0], mul_acc[54]} - {17'd0, den};

  // rounding of CORDIC outputs
  logic signed [27:0] rx, ry;
  logic signed [23:0] dxs, dys;
  assign rx = 28'((cx + 36'sd128) >>> 8);
  assign ry = 28'((cy + 36'sd128) >>> 8);
  assign dxs = (rx > 28'sd8388607) ? 24'sd8388607 :
               (rx < -28'sd8388608) ? -24'sd8388608 : 24'(rx);
  assign dys = (ry > 28'sd8388607) ? 24'sd8388607 :
               (ry < -28'sd8388608) ? -24'sd8388608 : 24'(ry);
  logic signed [32:0] nx, ny;
  assign nx = 33'(x_accum) + 33'(dxs);
  assign ny = 33'(y_accum) + 33'(dys);

  // midpoint angle and fold
  logic [15:0] mid;
  logic signed [16:0] a_s;
  assign mid = heading_accum + 16'(dth >>> 1);
  assign a_s = 17'($signed(mid));
  logic signed [35:0] gx;
  assign gx = sum[24] ? -$signed({1'b0, gmul_acc[54:22]}) - 36'sd1 + 36'(gmul_acc[21:0] == 0)
                      : $signed({3'b0, gmul_acc[54:22]});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      x_accum <= '0;
      y_accum <= '0;
      heading_accum <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          diff <= 25'(in_ch.right_distance) - 25'(in_ch.left_distance);
          sum <= (25'(in_ch.right_distance) + 25'(in_ch.left_distance)) >>> 1;
          mul_acc <= '0;
          gmul_acc <= '0;
          mcand_sh <= AngleGain;
          cnt <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          // shift-add one multiplier bit per cycle, both products share bit order
          if (mcand_sh[0]) mul_acc <= mul_acc + (55'(dmag) << cnt);
          if (CordicGainQ30[cnt[4:0]]) gmul_acc <= gmul_acc + (55'(smag) << cnt);
          mcand_sh <= mcand_sh >> 1;
          if (cnt == 6'd29) begin
            state <= S_DIV;
            cnt <= '0;
            rem <= '0;
            quo <= '0;
            den <= {half_track_width, 16'd0};
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle; mul_acc shifts out
          if (!trial[55]) begin
            rem <= trial[54:0];
            quo <= {quo[49:0], 1'b1};
          end else begin
            rem <= {rem[53:0], mul_acc[54]};
            quo <= {quo[49:0], 1'b0};
          end
          mul_acc <= {mul_acc[53:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd54) state <= S_QUO;
        end
        S_QUO: begin
          // zero track width turns fully toward the faster wheel
          if (half_track_width == 23'd0) begin
            dth <= (diff == 25'sd0) ? 16'sd0 : (diff[24] ? -16'sd32768 : 16'sd32767);
          end else begin
            dth <= dth_sat;
          end
          state <= S_LOAD;
        end
        S_LOAD: begin
          // load the folded vector and the angle in turn units
          cy <= '0;
          if (a_s > 17'sd16384) begin
            cx <= -gx; cz <= 34'(a_s - 17'sd32768) <<< 16;
          end else if (a_s < -17'sd16384) begin
            cx <= -gx; cz <= 34'(a_s + 17'sd32768) <<< 16;
          end else begin
            cx <= gx; cz <= 34'(a_s) <<< 16;
          end
          it <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (!cz[33]) begin
            cx <= cx - ys; cy <= cy + xs; cz <= cz - 34'(atan_turn32(it));
          end else begin
            cx <= cx + ys; cy <= cy - xs; cz <= cz + 34'(atan_turn32(it));
          end
          it <= it + 5'd1;
          if (32'(it) == NumSteps - 1) state <= S_ROUND;
        end
        S_ROUND: begin
          out_ch.step_x <= dxs;
          out_ch.step_y <= dys;
          out_ch.step_heading <= dth;
          x_accum <= (nx > 33'sd2147483647) ? 32'sh7FFFFFFF :
                     (nx < -33'sd2147483648) ? 32'sh80000000 : 32'(nx);
          y_accum <= (ny > 33'sd2147483647) ? 32'sh7FFFFFFF :
                     (ny < -33'sd2147483648) ? 32'sh80000000 : 32'(ny);
          heading_accum <= heading_accum + dth;
          state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.pos_x = x_accum;
  assign out_ch.pos_y = y_accum;
  assign out_ch.heading = heading_accum;

  // result is shown only after the round step
  a_out_after_round: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == S_ROUND) else $error("beat without round");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_accum_stable: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |=> $stable(heading_accum)) else $error("heading moved");
endmodule
`default_nettype wire
